/* hw/rtl/tlssa_pkg.sv */
package tlssa_pkg;

    // Store geometry
    localparam int SECTIONS = 8;
    localparam int DEVICES  = 8;

    localparam int SEC_AW  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int DEV_AW  = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int SEC_CW  = $clog2(SECTIONS + 1);
    localparam int DEV_CW  = $clog2(DEVICES + 1);
    localparam int ISS_W   = $clog2(2 * SECTIONS + 1);

    // One device entry: light[1:0], loaded[2], pending[3]
    localparam int ENTRY_W   = 4;
    localparam int E_LOADED  = 2;
    localparam int E_PENDING = 3;
    localparam int ROW_W     = DEVICES * ENTRY_W;

    // Field and port widths
    localparam int MASK_W     = 8;
    localparam int CNT_W      = 4;
    localparam int IN_W       = 16;
    localparam int OUT_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEC_CNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEV_CNT = 2'd3;

    // Request kinds
    localparam logic [1:0] ACT_SCAN  = 2'd0;
    localparam logic [1:0] ACT_PICK  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Light codes
    localparam logic [1:0] LIGHT_UNCHECKED = 2'd0;
    localparam logic [1:0] LIGHT_GREEN     = 2'd1;
    localparam logic [1:0] LIGHT_YELLOW    = 2'd2;
    localparam logic [1:0] LIGHT_RED       = 2'd3;

endpackage

/* hw/rtl/two_level_section_scan_arbiter.sv */
// Two-level section scan arbiter.
// Input stream (s_*): one request per accepted beat: a device scan report,
// a pick of the next section, or a clear of a section's first device.
// Result stream (m_*): exactly one result per request, in order, held in an
// output register until taken. Configuration is a plain write port
// (cfg_wr_en, cfg_index, cfg_wdata), to be written by the user only while
// the block is idle; the block itself does not enforce this. Device state
// sits in a one-port-read synchronous RAM, one row of all devices per
// section, with registered read data. Scan and clear: read-modify-write of
// one row per request. Pick: a start offset, (start + 1) mod n by repeated
// subtraction, then one row read per cycle over up to two passes of the
// used sections, then the output step.
// One request is in work at a time; s_tready is high only between them.
// A stalled m_tready holds the result; the next request is still taken and
// waits at its output step until the register frees.
// Reset (aresetn, synchronous) clears all device state through per-row
// valid bits at once, lowers every section priority, forgets the last
// pick and loads the register defaults; no clearing pass is needed.
module two_level_section_scan_arbiter (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // action[1:0], section[4:2], device[7:5], read_nonempty[8],
    // read_half_full[9], write_nonempty[10], zero[15:11]
    input  logic [tlssa_pkg::IN_W-1:0]          s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // prev_section[2:0], prev_valid[3], data_seen[4], write_pending[5],
    // zero[7:6]
    output logic [tlssa_pkg::OUT_W-1:0]         m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [tlssa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tlssa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import tlssa_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MOD  = 3'd1;
    localparam logic [2:0] ST_PICK = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_CLR  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]          state_reg, state_next;

    // Configuration
    logic                en_reg, en_next;
    logic [MASK_W-1:0]   mask_reg, mask_next;
    logic [CNT_W-1:0]    sec_cnt_reg, sec_cnt_next;
    logic [CNT_W-1:0]    dev_cnt_reg, dev_cnt_next;

    // Held request
    logic [2:0]          sec_reg, sec_next;
    logic [2:0]          dev_reg, dev_next;
    logic                rne_reg, rne_next;
    logic                rhf_reg, rhf_next;
    logic                wne_reg, wne_next;

    // Pick search
    logic [SEC_CW-1:0]   mod_reg, mod_next;
    logic [SEC_AW-1:0]   j_reg, j_next;
    logic [ISS_W-1:0]    iss_reg, iss_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [SEC_AW-1:0]   chk_sec_reg, chk_sec_next;
    logic                chk_high_reg, chk_high_next;
    logic                pick_vld_reg, pick_vld_next;
    logic [SEC_AW-1:0]   last_reg, last_next;

    // Section state
    logic [SECTIONS-1:0] prio_reg, prio_next;
    logic [SECTIONS-1:0] row_vld_reg, row_vld_next;

    // Result
    logic [OUT_W-1:0]    res_reg, res_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]    m_tdata_reg, m_tdata_next;

    // Device RAM
    logic [ROW_W-1:0]    row_mem [SECTIONS];
    logic [ROW_W-1:0]    rd_data_reg;
    logic [SEC_AW-1:0]   rd_addr;
    logic                mem_we;
    logic [ROW_W-1:0]    wr_row;

    // Derived
    logic [SEC_CW-1:0]   ns;
    logic [DEV_CW-1:0]   nd;
    logic [SECTIONS-1:0] sec_en_vec;
    logic                row_any;
    logic                hit;
    logic [ISS_W-1:0]    iss_lim;
    logic                out_load;
    logic                accept;

    logic [1:0]          in_act;
    logic [2:0]          in_sec;
    logic [2:0]          in_dev;

    assign in_act = s_tdata[1:0];
    assign in_sec = s_tdata[4:2];
    assign in_dev = s_tdata[7:5];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Counts in use, saturated to 1..max
    always_comb begin
        if (sec_cnt_reg == '0) begin
            ns = SEC_CW'(1);
        end else if (int'(sec_cnt_reg) > SECTIONS) begin
            ns = SEC_CW'(SECTIONS);
        end else begin
            ns = SEC_CW'(sec_cnt_reg);
        end
        if (dev_cnt_reg == '0) begin
            nd = DEV_CW'(1);
        end else if (int'(dev_cnt_reg) > DEVICES) begin
            nd = DEV_CW'(DEVICES);
        end else begin
            nd = DEV_CW'(dev_cnt_reg);
        end
    end

    // Per-section enable; sections past the mask width are never picked
    always_comb begin
        for (int i = 0; i < SECTIONS; i++) begin
            if (i < MASK_W) begin
                sec_en_vec[i] = mask_reg[i];
            end else begin
                sec_en_vec[i] = 1'b0;
            end
        end
    end

    // Any used device of the row under check not unchecked
    always_comb begin
        row_any = 1'b0;
        for (int k = 0; k < DEVICES; k++) begin
            if (k < int'(nd) && rd_data_reg[k*ENTRY_W +: 2] != LIGHT_UNCHECKED) begin
                row_any = 1'b1;
            end
        end
    end

    assign hit = chk_vld_reg && en_reg && sec_en_vec[chk_sec_reg]
                 && (prio_reg[chk_sec_reg] == chk_high_reg) && row_any;
    assign iss_lim  = ISS_W'(ns) << 1;
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    assign rd_addr  = (state_reg == ST_IDLE) ? SEC_AW'(in_sec) : j_reg;

    // Main control
    always_comb begin
        logic [ENTRY_W-1:0] e_old;
        logic [ENTRY_W-1:0] e_new;
        logic [1:0]         light;
        logic               prio;
        logic               seen;
        logic [SEC_AW-1:0]  start;
        logic [DEV_AW-1:0]  dev_idx;
        logic [SEC_AW-1:0]  sec_idx;

        state_next    = state_reg;
        en_next       = en_reg;
        mask_next     = mask_reg;
        sec_cnt_next  = sec_cnt_reg;
        dev_cnt_next  = dev_cnt_reg;
        sec_next      = sec_reg;
        dev_next      = dev_reg;
        rne_next      = rne_reg;
        rhf_next      = rhf_reg;
        wne_next      = wne_reg;
        mod_next      = mod_reg;
        j_next        = j_reg;
        iss_next      = iss_reg;
        chk_vld_next  = chk_vld_reg;
        chk_sec_next  = chk_sec_reg;
        chk_high_next = chk_high_reg;
        pick_vld_next = pick_vld_reg;
        last_next     = last_reg;
        prio_next     = prio_reg;
        row_vld_next  = row_vld_reg;
        res_next      = res_reg;
        mem_we        = 1'b0;
        wr_row        = rd_data_reg;

        dev_idx = DEV_AW'(dev_reg);
        sec_idx = SEC_AW'(sec_reg);
        e_old   = rd_data_reg[dev_idx*ENTRY_W +: ENTRY_W];
        e_new   = e_old;
        light   = e_old[1:0];
        prio    = prio_reg[sec_idx];
        seen    = 1'b0;
        start   = pick_vld_reg ? last_reg : '0;

        // Configuration writes
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ENABLE:  en_next      = cfg_wdata[0];
                REG_MASK:    mask_next    = cfg_wdata[MASK_W-1:0];
                REG_SEC_CNT: sec_cnt_next = cfg_wdata[CNT_W-1:0];
                REG_DEV_CNT: dev_cnt_next = cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    sec_next = in_sec;
                    dev_next = in_dev;
                    rne_next = s_tdata[8];
                    rhf_next = s_tdata[9];
                    wne_next = s_tdata[10];
                    res_next = '0;
                    case (in_act)
                        ACT_SCAN: begin
                            if (!en_reg || int'(in_sec) >= int'(ns)
                                    || int'(in_dev) >= int'(nd)) begin
                                state_next = ST_OUT;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        ACT_PICK: begin
                            mod_next   = SEC_CW'(start) + SEC_CW'(1);
                            state_next = ST_MOD;
                        end
                        ACT_CLEAR: begin
                            if (int'(in_sec) < SECTIONS) begin
                                state_next = ST_CLR;
                            end else begin
                                state_next = ST_OUT;
                            end
                        end
                        default: state_next = ST_OUT;
                    endcase
                end
            end

            // Start offset: (start + 1) mod n by repeated subtraction
            ST_MOD: begin
                if (mod_reg >= ns) begin
                    mod_next = mod_reg - ns;
                end else begin
                    j_next       = SEC_AW'(mod_reg);
                    iss_next     = '0;
                    chk_vld_next = 1'b0;
                    state_next   = ST_PICK;
                end
            end

            // One row read issued and one checked per cycle
            ST_PICK: begin
                if (iss_reg < iss_lim) begin
                    chk_vld_next  = 1'b1;
                    chk_sec_next  = j_reg;
                    chk_high_next = (iss_reg < ISS_W'(ns));
                    iss_next      = iss_reg + ISS_W'(1);
                    if (SEC_CW'(j_reg) + SEC_CW'(1) == ns) begin
                        j_next = '0;
                    end else begin
                        j_next = j_reg + SEC_AW'(1);
                    end
                end else begin
                    chk_vld_next = 1'b0;
                end
                if (hit || (!chk_vld_reg && iss_reg == iss_lim)) begin
                    res_next      = {4'b0000, pick_vld_reg,
                                     pick_vld_reg ? 3'(last_reg) : 3'b000};
                    pick_vld_next = hit;
                    last_next     = hit ? chk_sec_reg : '0;
                    chk_vld_next  = 1'b0;
                    state_next    = ST_OUT;
                end
            end

            // Age, then refresh the device entry
            ST_SCAN: begin
                if (e_old[E_LOADED]) begin
                    seen = 1'b1;
                    case (e_old[1:0])
                        LIGHT_UNCHECKED: light = LIGHT_GREEN;
                        LIGHT_GREEN: begin
                            light = LIGHT_YELLOW;
                            prio  = 1'b1;
                        end
                        LIGHT_YELLOW: light = LIGHT_RED;
                        default: ;
                    endcase
                end
                if (rne_reg) begin
                    seen             = 1'b1;
                    light            = LIGHT_GREEN;
                    e_new[E_LOADED]  = 1'b1;
                    prio             = rhf_reg;
                end else begin
                    light = LIGHT_UNCHECKED;
                end
                e_new[1:0]       = light;
                e_new[E_PENDING] = wne_reg;
                wr_row = rd_data_reg;
                wr_row[dev_idx*ENTRY_W +: ENTRY_W] = e_new;
                mem_we                = 1'b1;
                row_vld_next[sec_idx] = 1'b1;
                prio_next[sec_idx]    = prio;
                res_next   = {2'b00, wne_reg, seen, 4'b0000};
                state_next = ST_OUT;
            end

            // Clear the first device, keep its pending bit
            ST_CLR: begin
                wr_row = rd_data_reg;
                wr_row[1:0]           = LIGHT_UNCHECKED;
                wr_row[E_LOADED]      = 1'b0;
                mem_we                = 1'b1;
                row_vld_next[sec_idx] = 1'b1;
                prio_next[sec_idx]    = 1'b0;
                state_next            = ST_OUT;
            end

            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Output register
    always_comb begin
        m_tvalid_next = out_load || (m_tvalid_reg && !m_tready);
        m_tdata_next  = out_load ? res_reg : m_tdata_reg;
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            en_reg       <= 1'b0;
            mask_reg     <= '0;
            sec_cnt_reg  <= CNT_W'(8);
            dev_cnt_reg  <= CNT_W'(8);
            chk_vld_reg  <= 1'b0;
            pick_vld_reg <= 1'b0;
            last_reg     <= '0;
            prio_reg     <= '0;
            row_vld_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            en_reg       <= en_next;
            mask_reg     <= mask_next;
            sec_cnt_reg  <= sec_cnt_next;
            dev_cnt_reg  <= dev_cnt_next;
            chk_vld_reg  <= chk_vld_next;
            pick_vld_reg <= pick_vld_next;
            last_reg     <= last_next;
            prio_reg     <= prio_next;
            row_vld_reg  <= row_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        sec_reg      <= sec_next;
        dev_reg      <= dev_next;
        rne_reg      <= rne_next;
        rhf_reg      <= rhf_next;
        wne_reg      <= wne_next;
        mod_reg      <= mod_next;
        j_reg        <= j_next;
        iss_reg      <= iss_next;
        chk_sec_reg  <= chk_sec_next;
        chk_high_reg <= chk_high_next;
        res_reg      <= res_next;
        m_tdata_reg  <= m_tdata_next;
    end

    // Device RAM; a row never written since reset reads as cleared
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            row_mem[sec_reg[SEC_AW-1:0]] <= wr_row;
        end
        rd_data_reg <= row_vld_reg[rd_addr] ? row_mem[rd_addr] : '0;
    end

endmodule
